/* hw/rtl/sfla_pkg.sv */
// ----------------------------------------------------------------------------
// sfla_pkg
// Shared types and constants for the sorted free-list allocator.
// ----------------------------------------------------------------------------
package sfla_pkg;

    localparam int DEFAULT_DEPTH = 16;
    localparam int SIZE_W        = 16;
    localparam int STATUS_W      = 2;
    localparam int S_TDATA_W     = 16;
    localparam int M_TDATA_W     = 24;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_NOFIT = 2'd2,
        STATUS_FULL  = 2'd3
    } status_t;

    typedef enum logic {
        FUNC_GET    = 1'b0,
        FUNC_RETURN = 1'b1
    } func_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    typedef struct packed {
        logic load;
        logic exec;
    } cmd_t;

endpackage

/* hw/rtl/sfla_ctrl.sv */
// ----------------------------------------------------------------------------
// sfla_ctrl
// Sequencer: latches a request, fires the update, owns the result valid flag.
// ----------------------------------------------------------------------------
module sfla_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    output sfla_pkg::cmd_t cmd
);

    sfla_pkg::state_t state_reg, state_next;
    logic             m_valid_reg, m_valid_next;
    logic             out_free;

    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            sfla_pkg::ST_IDLE: begin
                if (s_tvalid) state_next = sfla_pkg::ST_EXEC;
            end
            sfla_pkg::ST_EXEC: begin
                if (out_free) state_next = sfla_pkg::ST_IDLE;
            end
            default: state_next = sfla_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        cmd      = '0;
        case (state_reg)
            sfla_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            sfla_pkg::ST_EXEC: begin
                cmd.exec = out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.exec)      m_valid_next = 1'b1;
        else if (m_tready) m_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sfla_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;

    // a taken item moves to exec on the next edge
    a_load_then_exec_state: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> state_reg == sfla_pkg::ST_EXEC)
        else $error("load did not enter exec");

    a_exec_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec |=> m_valid_reg)
        else $error("exec did not raise result valid");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_tready |=> m_valid_reg)
        else $error("waiting result dropped");

endmodule

/* hw/rtl/sfla_dpath.sv */
// ----------------------------------------------------------------------------
// sfla_dpath
// Sorted cell row with per-cell compare, shift-in/shift-out update and the
// result register.
// ----------------------------------------------------------------------------
module sfla_dpath #(
    parameter int DEPTH = sfla_pkg::DEFAULT_DEPTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  sfla_pkg::cmd_t                cmd,
    input  logic                          in_func,
    input  logic [sfla_pkg::SIZE_W-1:0]   in_size,
    output logic [sfla_pkg::SIZE_W-1:0]   out_granted,
    output logic [sfla_pkg::STATUS_W-1:0] out_status
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [sfla_pkg::SIZE_W-1:0] store_reg  [DEPTH];
    logic [sfla_pkg::SIZE_W-1:0] store_next [DEPTH];
    logic [CW-1:0]               count_reg, count_next;
    logic                        func_reg;
    logic [sfla_pkg::SIZE_W-1:0] size_reg;
    logic [sfla_pkg::SIZE_W-1:0] granted_reg, granted_next;
    sfla_pkg::status_t           status_reg, status_next;

    logic [DEPTH-1:0]            hit;
    logic [DEPTH-1:0]            first;
    logic [DEPTH-1:0]            ins;
    logic                        any_hit;
    logic                        is_full;
    logic                        is_empty;
    logic [sfla_pkg::SIZE_W-1:0] sel_size;

    // ascending store makes hit a monotone mask: first set bit marks the slot
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            hit[i] = (CW'(i) < count_reg) && (store_reg[i] >= size_reg);
        end
        first[0] = hit[0];
        for (int i = 1; i < DEPTH; i++) begin
            first[i] = hit[i] && !hit[i-1];
        end
        any_hit = |hit;
        for (int i = 0; i < DEPTH; i++) begin
            ins[i] = first[i] || (!any_hit && (CW'(i) == count_reg));
        end
        sel_size = '0;
        for (int i = 0; i < DEPTH; i++) begin
            sel_size = sel_size | (first[i] ? store_reg[i] : '0);
        end
    end

    assign is_full  = (count_reg == CW'(DEPTH));
    assign is_empty = (count_reg == '0);

    always_comb begin
        store_next   = store_reg;
        count_next   = count_reg;
        granted_next = granted_reg;
        status_next  = status_reg;
        if (cmd.exec) begin
            granted_next = '0;
            status_next  = sfla_pkg::STATUS_OK;
            if (func_reg == sfla_pkg::FUNC_GET) begin
                if (is_empty) begin
                    status_next = sfla_pkg::STATUS_EMPTY;
                end else if (!any_hit) begin
                    status_next = sfla_pkg::STATUS_NOFIT;
                end else begin
                    granted_next = sel_size;
                    count_next   = count_reg - CW'(1);
                    for (int i = 0; i < DEPTH - 1; i++) begin
                        if (hit[i]) store_next[i] = store_reg[i+1];
                    end
                end
            end else begin
                if (is_full) begin
                    status_next = sfla_pkg::STATUS_FULL;
                end else begin
                    count_next = count_reg + CW'(1);
                    // cells from the slot up to the old tail move up by one
                    for (int i = 1; i < DEPTH; i++) begin
                        if (hit[i-1]) store_next[i] = store_reg[i-1];
                    end
                    for (int i = 0; i < DEPTH; i++) begin
                        if (ins[i]) store_next[i] = size_reg;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        store_reg   <= store_next;
        granted_reg <= granted_next;
        status_reg  <= status_next;
        if (cmd.load) begin
            func_reg <= in_func;
            size_reg <= in_size;
        end
    end

    assign out_granted = granted_reg;
    assign out_status  = status_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("entry count above depth");

    a_get_ok_dec: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec && func_reg == sfla_pkg::FUNC_GET && any_hit
        |=> count_reg == $past(count_reg) - CW'(1) && status_reg == sfla_pkg::STATUS_OK)
        else $error("successful get did not remove one entry");

    a_full_only_at_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec && func_reg == sfla_pkg::FUNC_RETURN && !is_full
        |=> count_reg == $past(count_reg) + CW'(1))
        else $error("accepted return did not add one entry");

endmodule

/* hw/rtl/sorted_free_list_allocator.sv */
// ----------------------------------------------------------------------------
// sorted_free_list_allocator
// Best-fit allocator over an ascending list of free block sizes.
// ----------------------------------------------------------------------------
// The accepting edge latches the request; the update then compares the request
// against every stored size at once, shifts the cell row to remove or insert
// the entry and loads the result register. A new item is taken while a result
// still waits; the block stalls only if the result register is still full when
// the next update is due. A get returns the smallest stored size not below the
// request; a return inserts the size ahead of equal entries, and is dropped
// with status full when DEPTH entries are held.
// Status: 0 ok, 1 list empty, 2 no block large enough, 3 store full.
// ----------------------------------------------------------------------------
module sorted_free_list_allocator #(
    parameter int DEPTH = sfla_pkg::DEFAULT_DEPTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [sfla_pkg::S_TDATA_W-1:0] s_tdata,  // [15:0] block_size
    input  logic                           s_tuser,  // [0] func
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [sfla_pkg::M_TDATA_W-1:0] m_tdata   // [15:0] granted_size, [17:16] status
);

    sfla_pkg::cmd_t                cmd;
    logic [sfla_pkg::SIZE_W-1:0]   granted;
    logic [sfla_pkg::STATUS_W-1:0] status;

    sfla_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    sfla_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .in_func     (s_tuser),
        .in_size     (s_tdata[sfla_pkg::SIZE_W-1:0]),
        .out_granted (granted),
        .out_status  (status)
    );

    assign m_tdata = {{(sfla_pkg::M_TDATA_W - sfla_pkg::SIZE_W - sfla_pkg::STATUS_W){1'b0}},
                      status, granted};

endmodule
